@@ rtl/core/cdb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types and constants of the cosine distance block.
// ----------------------------------------------------------------------------
package cdb_pkg;

   localparam int MAX_COLUMNS_DEF = 16;
   localparam int MAX_LENGTH_DEF  = 1024;

   localparam int ACC_W  = 27;
   localparam int NORM_W = 29;
   localparam int DIST_W = 17;

   localparam logic [1:0] CMD_COL_BYTE = 2'd0;
   localparam logic [1:0] CMD_COL_NORM = 2'd1;
   localparam logic [1:0] CMD_ROW_BYTE = 2'd2;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   localparam logic CSR_TRACT_LENGTH   = 1'b0;
   localparam logic CSR_COLUMNS_IN_USE = 1'b1;

   localparam logic [10:0] TRACT_LENGTH_RST = 11'd1024;
   localparam logic [4:0]  COLUMNS_RST      = 5'd16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  column_index;
      logic [9:0]  position;
      logic [7:0]  byte_value;
      logic [28:0] norm_value;
      logic        row_end;
   } req_type;

   typedef struct packed {
      logic [16:0] distance;
      logic [3:0]  result_column;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [NORM_W-1:0] norm;
   } cell_data_type;

   typedef struct packed {
      logic col_wr;
      logic norm_wr;
      logic mac;
      logic capture;
      logic shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ rtl/core/cdb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdb_cell
// One column: byte store, norm, dot accumulator and readout shift stage.
// ----------------------------------------------------------------------------
module cdb_cell #(
   parameter int MAX_LENGTH = cdb_pkg::MAX_LENGTH_DEF,
   parameter int AW         = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
   input  wire                    clock,
   input  wire                    reset,
   input  cdb_pkg::cell_ctl_type  ctl,
   input  wire  [AW-1:0]          wr_addr,
   input  wire  [7:0]             wr_byte,
   input  wire  [AW-1:0]          rd_addr,
   input  wire  [28:0]            norm_in,
   input  wire  [7:0]             row_byte,
   input  cdb_pkg::cell_data_type shift_in,
   output cdb_pkg::cell_data_type shift_out
);

   logic [7:0]                mem [MAX_LENGTH];
   logic [7:0]                rd_data_ff;
   logic [cdb_pkg::NORM_W-1:0] norm_ff;
   logic [cdb_pkg::ACC_W-1:0]  acc_ff;
   logic [cdb_pkg::ACC_W-1:0]  acc_in;
   logic [cdb_pkg::ACC_W:0]    sum;
   logic [15:0]                prod;
   cdb_pkg::cell_data_type     out_ff;

   always_ff @(posedge clock) begin
      if (ctl.col_wr) begin
         mem[wr_addr] <= wr_byte;
      end
      rd_data_ff <= mem[rd_addr];
      if (ctl.norm_wr) begin
         norm_ff <= norm_in;
      end
   end

   always_comb begin
      prod = row_byte * rd_data_ff;
      sum  = {1'b0, acc_ff} + (cdb_pkg::ACC_W + 1)'(prod);
      if (ctl.mac) begin
         acc_in = sum[cdb_pkg::ACC_W] ? '1 : sum[cdb_pkg::ACC_W-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.capture) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // readout chain toward column 0
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         out_ff.acc  <= acc_in;
         out_ff.norm <= norm_ff;
      end else if (ctl.shift) begin
         out_ff <= shift_in;
      end
   end

   assign shift_out = out_ff;

endmodule
`default_nettype wire

@@ rtl/core/cosine_distance_block_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_distance_block_core
// Cosine distance of a streamed row against stored byte columns.
//
// A word on req_data is taken when start is high and busy is low. Column
// byte and column norm words leave busy low and return nothing. A row byte
// first reads the column stores, then each column cell below columns_in_use
// multiplies and accumulates in parallel if the position is below
// tract_length. On the row's last byte the accumulators are captured into
// a shift chain of cells and cleared; the chain walks one column per result
// into a shared 29x29 multiplier and a bit-serial divider. Each result
// passes through multiply and set-up, then, unless a norm is zero or the
// quotient saturates, a division of 16 quotient bits; column 0 first. Each
// result word sits on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall. busy stays high until the last word of a row is
// out. Registers are written on csr_we at any time and read back never.
// Reset sets tract_length to 1024, columns_in_use to 16 and clears the
// accumulators; column stores and norms hold garbage until written.
// ----------------------------------------------------------------------------
module cosine_distance_block_core #(
   parameter int MAX_COLUMNS = cdb_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_LENGTH  = cdb_pkg::MAX_LENGTH_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  cdb_pkg::req_type req_data,
   output logic             rsp_valid,
   output cdb_pkg::rsp_type rsp_data,
   input  wire              csr_we,
   input  wire              csr_index,
   input  wire  [10:0]      csr_wdata
);

   localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CW = $clog2(MAX_COLUMNS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_MUL, S_PREP, S_DIV
   } state_type;

   state_type          state_ff;
   logic [10:0]        tract_ff;
   logic [4:0]         cols_ff;
   logic [7:0]         byte_ff;
   logic               mac_ok_ff;
   logic               row_end_ff;
   logic [28:0]        row_norm_ff;
   logic [CW-1:0]      k_ff;
   logic [57:0]        prod_ff;
   logic [26:0]        dot_ff;
   logic [59:0]        rem_ff;
   logic [15:0]        q_ff;
   logic [3:0]         step_ff;
   logic               rsp_valid_ff;
   cdb_pkg::rsp_type   rsp_ff;

   logic               accept;
   logic [CW-1:0]      used;
   logic               done_w;
   logic [16:0]        dist_w;
   logic [59:0]        rem_sh;
   logic [59:0]        prod_ext;
   logic [59:0]        rem_init;
   logic               ge;
   logic [59:0]        rem_in;
   logic [15:0]        q_in;
   logic               pos_in_mem;
   logic [AW-1:0]      addr;

   cdb_pkg::cell_ctl_type  ctl   [MAX_COLUMNS];
   cdb_pkg::cell_data_type chain [MAX_COLUMNS+1];

   assign accept     = start && !busy;
   assign busy       = (state_ff != S_IDLE);
   assign pos_in_mem = (32'(req_data.position) < MAX_LENGTH);
   assign addr       = AW'(req_data.position);
   assign used       = (32'(cols_ff) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cols_ff);

   always_comb begin
      prod_ext = 60'(prod_ff);
      rem_init = {1'b0, dot_ff, 32'b0};
      rem_sh   = {rem_ff[58:0], 1'b0};
      ge       = (rem_sh >= prod_ext);
      rem_in   = ge ? (rem_sh - prod_ext) : rem_sh;
      q_in     = {q_ff[14:0], ge};
      done_w   = 1'b0;
      dist_w   = 17'd65536;
      case (state_ff)
         S_PREP: begin
            if (prod_ff == '0) begin
               done_w = 1'b1;
               dist_w = 17'd65536;
            end else if (rem_init >= prod_ext) begin
               done_w = 1'b1;
               dist_w = 17'd0;
            end
         end
         S_DIV: begin
            if (step_ff == 4'd15) begin
               done_w = 1'b1;
               dist_w = 17'd65536 - {1'b0, q_in};
            end
         end
         default: begin
            done_w = 1'b0;
         end
      endcase
   end

   assign chain[MAX_COLUMNS] = '0;

   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
      always_comb begin
         ctl[i].col_wr  = accept && (req_data.cmd == cdb_pkg::CMD_COL_BYTE) &&
                          (32'(req_data.column_index) == i) && pos_in_mem;
         ctl[i].norm_wr = accept && (req_data.cmd == cdb_pkg::CMD_COL_NORM) &&
                          (32'(req_data.column_index) == i);
         ctl[i].mac     = (state_ff == S_MAC) && mac_ok_ff && (CW'(i) < used);
         ctl[i].capture = (state_ff == S_MAC) && row_end_ff;
         ctl[i].shift   = done_w;
      end

      cdb_cell #(
         .MAX_LENGTH (MAX_LENGTH),
         .AW         (AW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[i]),
         .wr_addr   (addr),
         .wr_byte   (req_data.byte_value),
         .rd_addr   (addr),
         .norm_in   (req_data.norm_value),
         .row_byte  (byte_ff),
         .shift_in  (chain[i+1]),
         .shift_out (chain[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tract_ff     <= cdb_pkg::TRACT_LENGTH_RST;
         cols_ff      <= cdb_pkg::COLUMNS_RST;
      end else begin
         rsp_valid_ff <= done_w;
         if (csr_we) begin
            case (csr_index)
               cdb_pkg::CSR_TRACT_LENGTH:   tract_ff <= csr_wdata;
               cdb_pkg::CSR_COLUMNS_IN_USE: cols_ff  <= csr_wdata[4:0];
               default:                     tract_ff <= tract_ff;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_data.cmd == cdb_pkg::CMD_ROW_BYTE) begin
                  byte_ff     <= req_data.byte_value;
                  mac_ok_ff   <= (11'(req_data.position) < tract_ff) && pos_in_mem;
                  row_end_ff  <= req_data.row_end;
                  row_norm_ff <= req_data.norm_value;
                  state_ff    <= S_MAC;
               end
            end
            S_MAC: begin
               k_ff <= '0;
               if (row_end_ff && used != '0) begin
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_MUL: begin
               prod_ff  <= row_norm_ff * chain[0].norm;
               dot_ff   <= chain[0].acc;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               rem_ff   <= rem_init;
               q_ff     <= '0;
               step_ff  <= '0;
               if (!done_w) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff  <= rem_in;
               q_ff    <= q_in;
               step_ff <= step_ff + 4'd1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (done_w) begin
            rsp_ff.distance           <= dist_w;
            rsp_ff.result_column      <= 4'(k_ff);
            rsp_ff.last_result        <= (k_ff + CW'(1) == used);
            k_ff                      <= k_ff + CW'(1);
            state_ff                  <= (k_ff + CW'(1) == used) ? S_IDLE : S_MUL;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
